### hdl/mouse_packet_cursor_tracker_assert.svh
// assertion macros for the cursor tracker
// each macro expects clk and rst_n in the scope where it is used
`ifndef MOUSE_PACKET_CURSOR_TRACKER_ASSERT_SVH
`define MOUSE_PACKET_CURSOR_TRACKER_ASSERT_SVH

// same-cycle implication, off during reset
`define MPCT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define MPCT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/mpct_pkg.sv
`default_nettype none
package mpct_pkg;

  localparam int COORD_BITS     = 10;
  localparam int OUT_COORD_BITS = 10;
  localparam int LIMIT_BITS     = 10;
  localparam int MOVE_BITS      = 9;
  localparam int CFG_IDX_BITS   = 1;
  localparam int SUM_BITS       = ((COORD_BITS > LIMIT_BITS) ? COORD_BITS : LIMIT_BITS) + 2;

  localparam logic [COORD_BITS-1:0] COORD_MAX   = {COORD_BITS{1'b1}};
  localparam logic [COORD_BITS-1:0] POS_X_RESET = COORD_BITS'(160);
  localparam logic [COORD_BITS-1:0] POS_Y_RESET = COORD_BITS'(120);
  localparam logic [LIMIT_BITS-1:0] X_LIMIT_RESET = LIMIT_BITS'(314);
  localparam logic [LIMIT_BITS-1:0] Y_LIMIT_RESET = LIMIT_BITS'(234);

  // status byte bit positions
  localparam int SYNC_POS  = 3;
  localparam int XSIGN_POS = 4;
  localparam int YSIGN_POS = 5;
  localparam int XOVF_POS  = 6;
  localparam int YOVF_POS  = 7;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_X_LIMIT = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_Y_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    SLOT_STATUS = 2'd0,
    SLOT_XMOVE  = 2'd1,
    SLOT_YMOVE  = 2'd2
  } byte_slot_t;

  typedef struct packed {
    logic [7:0] status;
    logic [7:0] x_byte;
    logic [7:0] y_byte;
  } packet_t;

  // handshake between the packet queue and the cursor stage
  typedef struct packed {
    logic    valid;
    packet_t pkt;
  } queue_head_t;

endpackage
`default_nettype wire

### hdl/mpct_if.sv
`default_nettype none
// received byte channel
interface mpct_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// cursor result channel
interface mpct_cursor_if import mpct_pkg::*; ;
  logic                             valid;
  logic                             ready;
  logic        [OUT_COORD_BITS-1:0] cursor_x;
  logic        [OUT_COORD_BITS-1:0] cursor_y;
  logic signed [MOVE_BITS-1:0]      move_x;
  logic signed [MOVE_BITS-1:0]      move_y;
  logic                             x_overflow;
  logic                             y_overflow;

  modport source (output valid, output cursor_x, output cursor_y, output move_x,
                  output move_y, output x_overflow, output y_overflow, input ready);
  modport sink   (input valid, input cursor_x, input cursor_y, input move_x,
                  input move_y, input x_overflow, input y_overflow, output ready);
endinterface
`default_nettype wire

### hdl/mpct_front.sv
`default_nettype none
module mpct_front import mpct_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire logic [7:0] in_byte,
  output logic         push_valid,
  output packet_t      push_pkt,
  input  wire logic    queue_full
);

  byte_slot_t slot_r, slot_nxt;
  logic [7:0] status_r, status_nxt;
  logic [7:0] xbyte_r, xbyte_nxt;
  logic       take;

  // only the closing byte needs room in the queue
  assign in_ready = !(queue_full && (slot_r != SLOT_STATUS) && (slot_r != SLOT_XMOVE));
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= SLOT_STATUS;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    xbyte_r  <= xbyte_nxt;
  end

  always_comb begin
    slot_nxt   = slot_r;
    status_nxt = status_r;
    xbyte_nxt  = xbyte_r;
    push_valid = 1'b0;
    push_pkt   = '{status: status_r, x_byte: xbyte_r, y_byte: in_byte};
    unique case (slot_r)
      SLOT_STATUS: begin
        // resync: drop a first byte without the always-one bit
        if (take && in_byte[SYNC_POS]) begin
          status_nxt = in_byte;
          slot_nxt   = SLOT_XMOVE;
        end
      end
      SLOT_XMOVE: begin
        if (take) begin
          xbyte_nxt = in_byte;
          slot_nxt  = SLOT_YMOVE;
        end
      end
      default: begin
        if (take) begin
          push_valid = 1'b1;
          slot_nxt   = SLOT_STATUS;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

### hdl/mpct_queue.sv
`default_nettype none
module mpct_queue import mpct_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push_valid,
  input  wire packet_t push_pkt,
  output logic         full,
  output queue_head_t  head,
  input  wire logic    pop
);

  packet_t    mem [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push;

  assign full       = (count_r == 2'd2);
  assign do_push    = push_valid && !full;
  assign head.valid = (count_r != 2'd0);
  assign head.pkt   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_pkt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (pop)     rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + 2'(do_push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

### hdl/mpct_back.sv
`default_nettype none
module mpct_back import mpct_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [LIMIT_BITS-1:0]   cfg_wdata,
  input  wire queue_head_t             head,
  output logic                         pop,
  mpct_cursor_if.source                out_ch
);

  logic [LIMIT_BITS-1:0] x_limit_r, y_limit_r;
  logic [COORD_BITS-1:0] pos_x_r, pos_y_r, pos_x_nxt, pos_y_nxt;
  logic                  out_valid_r;
  logic signed [MOVE_BITS-1:0] dx, dy, dx_r, dy_r;
  logic                  xo, yo, xo_r, yo_r;
  logic signed [SUM_BITS-1:0] sum_x, sum_y;

  function automatic logic [COORD_BITS-1:0] clamp_coord(
    input logic signed [SUM_BITS-1:0] v,
    input logic [LIMIT_BITS-1:0]      lim
  );
    logic signed [SUM_BITS-1:0] hi;
    hi = $signed(SUM_BITS'(lim));
    if (hi > $signed(SUM_BITS'(COORD_MAX))) hi = $signed(SUM_BITS'(COORD_MAX));
    if (v < 0)        return '0;
    else if (v > hi)  return COORD_BITS'(hi);
    else              return COORD_BITS'(v);
  endfunction

  assign pop = head.valid && (!out_valid_r || out_ch.ready);

  assign xo = head.pkt.status[XOVF_POS];
  assign yo = head.pkt.status[YOVF_POS];
  assign dx = xo ? '0 : $signed({head.pkt.status[XSIGN_POS], head.pkt.x_byte});
  assign dy = yo ? '0 : $signed({head.pkt.status[YSIGN_POS], head.pkt.y_byte});

  assign sum_x = $signed(SUM_BITS'(pos_x_r)) + SUM_BITS'(dx);
  assign sum_y = $signed(SUM_BITS'(pos_y_r)) - SUM_BITS'(dy);
  assign pos_x_nxt = clamp_coord(sum_x, x_limit_r);
  assign pos_y_nxt = clamp_coord(sum_y, y_limit_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_limit_r <= X_LIMIT_RESET;
      y_limit_r <= Y_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_X_LIMIT: x_limit_r <= cfg_wdata;
        REG_Y_LIMIT: y_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r     <= POS_X_RESET;
      pos_y_r     <= POS_Y_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        pos_x_r <= pos_x_nxt;
        pos_y_r <= pos_y_nxt;
      end
      if (pop) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      dx_r <= dx;
      dy_r <= dy;
      xo_r <= xo;
      yo_r <= yo;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.cursor_x   = OUT_COORD_BITS'(pos_x_r);
  assign out_ch.cursor_y   = OUT_COORD_BITS'(pos_y_r);
  assign out_ch.move_x     = dx_r;
  assign out_ch.move_y     = dy_r;
  assign out_ch.x_overflow = xo_r;
  assign out_ch.y_overflow = yo_r;

endmodule
`default_nettype wire

### hdl/mouse_packet_cursor_tracker.sv
// channel    | dir | handshake      | payload
// -----------+-----+----------------+---------------------------------------------
// in_ch      | in  | valid / ready  | rx_byte[7:0]
// out_ch     | out | valid / ready  | cursor_x/y[9:0], move_x/y[8:0] s, x/y_overflow
// cfg_*      | in  | cfg_we only    | cfg_index[0], cfg_wdata[9:0]
//
// one byte request per cycle while in_ready is high; after its third byte a packet
// result passes through the packet queue and then through the output register
// sustained rate: one byte a cycle unless stalled; add and clamp are combinational
// the front only stalls on a closing byte when the two-entry queue is full
// synchronous active-low reset: cursor at 160/120, limits 314/234, no packet open
`default_nettype none
module mouse_packet_cursor_tracker import mpct_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [LIMIT_BITS-1:0]   cfg_wdata,
  mpct_byte_if.sink                    in_ch,
  mpct_cursor_if.source                out_ch
);

  // front to queue
  logic        push_valid;
  packet_t     push_pkt;
  logic        queue_full;

  // queue to back
  queue_head_t head;
  logic        pop;

  // front: byte slot tracking, resync on the first byte, packet assembly
  mpct_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_byte    (in_ch.rx_byte),
    .push_valid (push_valid),
    .push_pkt   (push_pkt),
    .queue_full (queue_full)
  );

  // short queue so a stalled result side does not block byte intake at once
  mpct_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_pkt   (push_pkt),
    .full       (queue_full),
    .head       (head),
    .pop        (pop)
  );

  // back: move decode, cursor update with clamp, result register, limits
  mpct_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .head      (head),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

### hdl/mpct_checker.sv
`default_nettype none
`include "mouse_packet_cursor_tracker_assert.svh"
module mpct_checker import mpct_pkg::*; (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [OUT_COORD_BITS-1:0]   out_cursor_x,
  input wire logic [OUT_COORD_BITS-1:0]   out_cursor_y,
  input wire logic signed [MOVE_BITS-1:0] out_move_x,
  input wire logic signed [MOVE_BITS-1:0] out_move_y,
  input wire logic                        out_x_overflow,
  input wire logic                        out_y_overflow
);

  `MPCT_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_cursor_x) && $stable(out_cursor_y), "result dropped while stalled")

  `MPCT_ASSERT_IMP(a_x_ovf_zero, out_valid && out_x_overflow, out_move_x == '0,
    "x move not cleared on overflow")

  `MPCT_ASSERT_IMP(a_y_ovf_zero, out_valid && out_y_overflow, out_move_y == '0,
    "y move not cleared on overflow")

  `MPCT_ASSERT_IMP(a_reset_quiet, $past(!rst_n), !out_valid,
    "result valid right after reset")

endmodule

bind mouse_packet_cursor_tracker mpct_checker u_mpct_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_cursor_x   (out_ch.cursor_x),
  .out_cursor_y   (out_ch.cursor_y),
  .out_move_x     (out_ch.move_x),
  .out_move_y     (out_ch.move_y),
  .out_x_overflow (out_ch.x_overflow),
  .out_y_overflow (out_ch.y_overflow)
);
`default_nettype wire

### tb/mpct_cursor_check.sv
`timescale 1ns / 100ps
module mpct_cursor_check import mpct_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [LIMIT_BITS-1:0]   cfg_wdata,
  mpct_byte_if                    byte_mon,
  mpct_cursor_if                  cursor_mon,
  output int                      fail_count,
  output int                      pending_results
);

  typedef struct packed {
    logic        [OUT_COORD_BITS-1:0] cursor_x;
    logic        [OUT_COORD_BITS-1:0] cursor_y;
    logic signed [MOVE_BITS-1:0]      move_x;
    logic signed [MOVE_BITS-1:0]      move_y;
    logic                             x_overflow;
    logic                             y_overflow;
  } cursor_result_t;

  cursor_result_t        cursor_q[$];
  int                    fails;
  logic [LIMIT_BITS-1:0] x_lim;
  logic [LIMIT_BITS-1:0] y_lim;
  byte_slot_t            slot;
  logic [7:0]            status_q;
  logic [7:0]            x_byte_q;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;

  initial begin
    fails = 0;
    fail_count = 0;
    pending_results = 0;
  end

  function automatic logic [COORD_BITS-1:0] clamp_coord(input int v,
                                                       input logic [LIMIT_BITS-1:0] lim);
    int hi;
    hi = int'(lim);
    if (hi > int'(COORD_MAX)) hi = int'(COORD_MAX);
    if (v < 0) return '0;
    if (v > hi) return COORD_BITS'(hi);
    return COORD_BITS'(v);
  endfunction

  // packet assembly and cursor update, one received byte at a time
  function automatic bit advance_tracker(input logic [7:0] b, output cursor_result_t r);
    int dx;
    int dy;
    r = '0;
    if (slot == SLOT_STATUS) begin
      if (b[SYNC_POS]) begin
        status_q = b;
        slot = SLOT_XMOVE;
      end
      return 1'b0;
    end
    if (slot == SLOT_XMOVE) begin
      x_byte_q = b;
      slot = SLOT_YMOVE;
      return 1'b0;
    end
    slot = SLOT_STATUS;
    dx = int'(x_byte_q) - (status_q[XSIGN_POS] ? 256 : 0);
    dy = int'(b) - (status_q[YSIGN_POS] ? 256 : 0);
    if (status_q[XOVF_POS]) dx = 0;
    if (status_q[YOVF_POS]) dy = 0;
    pos_x = clamp_coord(int'(pos_x) + dx, x_lim);
    pos_y = clamp_coord(int'(pos_y) - dy, y_lim);
    r.cursor_x   = OUT_COORD_BITS'(pos_x);
    r.cursor_y   = OUT_COORD_BITS'(pos_y);
    r.move_x     = MOVE_BITS'(dx);
    r.move_y     = MOVE_BITS'(dy);
    r.x_overflow = status_q[XOVF_POS];
    r.y_overflow = status_q[YOVF_POS];
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    cursor_result_t got;
    cursor_result_t want;
    if (!rst_n) begin
      cursor_q.delete();
      x_lim    = X_LIMIT_RESET;
      y_lim    = Y_LIMIT_RESET;
      slot     = SLOT_STATUS;
      status_q = '0;
      x_byte_q = '0;
      pos_x    = POS_X_RESET;
      pos_y    = POS_Y_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_X_LIMIT: x_lim = cfg_wdata;
          REG_Y_LIMIT: y_lim = cfg_wdata;
          default: ;
        endcase
      end
      if (cursor_mon.valid && cursor_mon.ready) begin
        got.cursor_x   = cursor_mon.cursor_x;
        got.cursor_y   = cursor_mon.cursor_y;
        got.move_x     = cursor_mon.move_x;
        got.move_y     = cursor_mon.move_y;
        got.x_overflow = cursor_mon.x_overflow;
        got.y_overflow = cursor_mon.y_overflow;
        if (cursor_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual x=%0d y=%0d", $time,
                   got.cursor_x, got.cursor_y);
          fails++;
        end else begin
          want = cursor_q.pop_front();
          check_field("cursor_x", int'(want.cursor_x), int'(got.cursor_x));
          check_field("cursor_y", int'(want.cursor_y), int'(got.cursor_y));
          check_field("move_x", int'(want.move_x), int'(got.move_x));
          check_field("move_y", int'(want.move_y), int'(got.move_y));
          check_field("x_overflow", int'(want.x_overflow), int'(got.x_overflow));
          check_field("y_overflow", int'(want.y_overflow), int'(got.y_overflow));
        end
      end
      if (byte_mon.valid && byte_mon.ready) begin
        if (advance_tracker(byte_mon.rx_byte, want)) cursor_q.push_back(want);
      end
    end
    pending_results <= cursor_q.size();
    fail_count      <= fails;
  end

endmodule

### tb/mouse_packet_cursor_tracker_tb.sv
`timescale 1ns / 100ps
module mouse_packet_cursor_tracker_tb;
  import mpct_pkg::*;

  // run limit, far above the slowest legal run
  localparam int CYCLE_LIMIT = 200000;
  // receiver hold-off length for the back-pressure test
  localparam int HOLD_CYCLES = 300;
  // packet bytes per random phase
  localparam int PHASE_ITEMS = 125;
  localparam int NUM_PHASES  = 6;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [LIMIT_BITS-1:0]   cfg_wdata = '0;

  int         fail_count;
  int         pending;
  int         cycle_count = 0;
  idle_mode_t idle_mode = IDLE_NONE;
  bit         hold_trigger = 1'b0;

  mpct_byte_if   byte_ch ();
  mpct_cursor_if cursor_ch ();

  mouse_packet_cursor_tracker uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (byte_ch),
    .out_ch    (cursor_ch)
  );

  // prediction and comparison live in the monitor
  mpct_cursor_check monitor (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .byte_mon        (byte_ch),
    .cursor_mon      (cursor_ch),
    .fail_count      (fail_count),
    .pending_results (pending)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("mouse_packet_cursor_tracker_tb NOT OK");
      $finish;
    end
  end

  // chance in percent that a side skips a cycle in the current phase
  function automatic int unsigned idle_pct(input bit receiver_side);
    case (idle_mode)
      IDLE_SENDER:   return receiver_side ? 0 : 48;
      IDLE_RECEIVER: return receiver_side ? 48 : 0;
      IDLE_BOTH:     return 21;
      default:       return 0;
    endcase
  endfunction

  // result receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    bit hold_started;
    hold_left = 0;
    hold_started = 1'b0;
    cursor_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_trigger && !hold_started) begin
        hold_started = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        cursor_ch.ready <= 1'b0;
      end else begin
        cursor_ch.ready <= ($urandom_range(99) >= idle_pct(1'b1));
      end
    end
  end

  // one byte request; valid stays high afterwards so back-to-back requests
  // need no extra assignment
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct(1'b0)) begin
      @(negedge clk);
      byte_ch.valid <= 1'b0;
    end
    @(negedge clk);
    byte_ch.valid   <= 1'b1;
    byte_ch.rx_byte <= b;
    do @(posedge clk); while (!byte_ch.ready);
  endtask

  // stop offering bytes and wait for every predicted result, then let the
  // pipeline settle so a register write cannot touch work in flight
  task automatic drain();
    @(negedge clk);
    byte_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [LIMIT_BITS-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    // unsynchronized bytes first, then extreme moves, signs and overflows
    logic [7:0] directed_bytes [23] = '{
      8'h00, 8'hF7,
      8'h08, 8'h00, 8'h00,
      8'h08, 8'hFF, 8'h00,
      8'h18, 8'h00, 8'h00,
      8'h28, 8'h00, 8'h00,
      8'h08, 8'h7F, 8'hFF,
      8'hC8, 8'hFF, 8'hFF,
      8'hF8, 8'hFF, 8'hFF
    };
    logic [LIMIT_BITS-1:0] x_set [NUM_PHASES] = '{10'd1023, 10'd0, 10'd0, 10'd1023, 10'd0, 10'd0};
    logic [LIMIT_BITS-1:0] y_set [NUM_PHASES] = '{10'd1023, 10'd0, 10'd0, 10'd0, 10'd0, 10'd1023};
    logic [7:0]  status;
    logic [7:0]  xb;
    logic [7:0]  yb;
    int unsigned pick;
    int          items;

    byte_ch.valid   = 1'b0;
    byte_ch.rx_byte = '0;
    x_set[2] = LIMIT_BITS'($urandom_range(1023));
    y_set[2] = LIMIT_BITS'($urandom_range(1023));
    x_set[4] = LIMIT_BITS'($urandom_range(1023));
    y_set[4] = LIMIT_BITS'($urandom_range(1023));

    // synchronous reset, held at the start
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed part at reset limits
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

    // lower the limits, x below the current position; the next packet clamps it
    drain();
    write_reg(REG_X_LIMIT, 10'd100);
    write_reg(REG_Y_LIMIT, 10'd50);
    send_byte(8'h08);
    send_byte(8'h40);
    send_byte(8'h80);
    send_byte(8'h08);
    send_byte(8'h00);
    send_byte(8'h00);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain();
      write_reg(REG_X_LIMIT, x_set[phase]);
      write_reg(REG_Y_LIMIT, y_set[phase]);
      idle_mode = idle_mode_t'(phase % 4);
      // long receiver hold-off while bytes keep coming, fills the queue
      if (phase == 0) hold_trigger = 1'b1;
      items = 0;
      while (items < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 12) begin
          // noise byte, may or may not look like a status byte
          send_byte(8'($urandom_range(255)));
          items++;
        end else begin
          status = 8'($urandom_range(255));
          status[SYNC_POS] = 1'b1;
          if ($urandom_range(3) != 0) status[XOVF_POS] = 1'b0;
          if ($urandom_range(3) != 0) status[YOVF_POS] = 1'b0;
          xb = 8'($urandom_range(255));
          yb = 8'($urandom_range(255));
          // about half the packets get small moves so the cursor wanders inside the limits
          if ($urandom_range(1) != 0) begin
            xb = 8'($urandom_range(15));
            if (status[XSIGN_POS]) xb = ~xb;
            yb = 8'($urandom_range(15));
            if (status[YSIGN_POS]) yb = ~yb;
          end
          send_byte(status);
          send_byte(xb);
          items += 2;
          // closing byte; pick is at least 12 here, so no packet is cut short
          if (pick >= 6) begin
            send_byte(yb);
            items++;
          end
        end
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("mouse_packet_cursor_tracker_tb OK");
    end else begin
      $display("mouse_packet_cursor_tracker_tb NOT OK");
    end
    $finish;
  end

endmodule
